/* hdl/ahdsr_pkg.sv */
// Shared constants and helpers of the AHDSR envelope generator.
// Depends on nothing; every other file of the block imports it.
package ahdsr_pkg;

  // Fixed widths of the level, the envelope and the codes.
  localparam int unsigned LEVEL_W    = 32;
  localparam int unsigned ENV_W      = 16;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SUS_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Full scale in Q31.
  localparam logic [LEVEL_W-1:0] UNITY_Q31 = 32'h8000_0000;

  // Commands carried by an input item.
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESET    = 2'd3;

  // Envelope phases as reported on the result.
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_HOLD    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd4;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd4;

  // Sustain level to Q31, floor(s * 2^31 / 65535). The two terms s * 2^15 and
  // s / 2 do not overlap, so the sum is a concatenation; full scale is exact.
  function automatic logic [LEVEL_W-1:0] sustain_to_q31(input logic [SUS_W-1:0] s);
    logic [LEVEL_W-1:0] res;
    if (s == '1) begin
      res = UNITY_Q31;
    end else begin
      res = {1'b0, s, s[SUS_W-1:1]};
    end
    return res;
  endfunction

  // Q31 level to the 16-bit envelope, floor(level * 65535 / 2^31).
  function automatic logic [ENV_W-1:0] level_to_env(input logic [LEVEL_W-1:0] level);
    logic [LEVEL_W+ENV_W-1:0] prod;
    prod = {level, {ENV_W{1'b0}}} - {{ENV_W{1'b0}}, level};
    return prod[LEVEL_W+ENV_W-2:LEVEL_W-1];
  endfunction

endpackage

/* hdl/ahdsr_in_if.sv */
// Command channel of the envelope generator: one item per command.
// Depends on ahdsr_pkg for the command width.
interface ahdsr_in_if import ahdsr_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              command;
  logic signed [SAMPLE_BITS-1:0] audio_in;

  modport source (output valid, output command, output audio_in, input ready);
  modport sink   (input valid, input command, input audio_in, output ready);
endinterface

/* hdl/ahdsr_out_if.sv */
// Result channel of the envelope generator: one item per command.
// Depends on ahdsr_pkg for the envelope and phase widths.
interface ahdsr_out_if import ahdsr_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] audio_out;
  logic [ENV_W-1:0]              envelope_out;
  logic [PHASE_W-1:0]            phase_out;

  modport source (output valid, output audio_out, output envelope_out, output phase_out,
                  input ready);
  modport sink   (input valid, input audio_out, input envelope_out, input phase_out,
                  output ready);
endinterface

/* hdl/ahdsr_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on ahdsr_pkg for the index and data widths.
interface ahdsr_cfg_if import ahdsr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/ahdsr_envelope_generator.sv */
// AHDSR envelope generator. Each command item yields one result item. A
// command is taken only while the sequencer is idle. A finished result waits
// in the output register, so the next command may enter before it is taken;
// the sequencer then holds its own result until that register is free.
// A note on, a reset or a note off with a zero release length passes from idle
// through S_ENV to S_OUT. A tick in hold, sustain, release or idle, or a tick
// that ends a zero-length attack or decay, also runs the bit-serial multiplier
// that scales the sample, in S_MUL. A tick in attack or decay with a nonzero
// length first runs the bit-serial divider, one quotient bit per cycle over 32
// bits, and in decay then the sustain compare in S_DCMP. A note off with a
// nonzero release length runs only the divider, not the multiplier. The
// sequencer returns to idle, ready for the next command, as the result is
// registered. Levels are Q31 with full scale at 2^31. Configuration writes are
// taken at any time and are meant to arrive while no command is in flight.
module ahdsr_envelope_generator import ahdsr_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 24,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  ahdsr_in_if.sink   cmd_i,
  ahdsr_out_if.source res_o,
  ahdsr_cfg_if.sink  cfg_i
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_DCMP = 3'd2;
  localparam logic [2:0] S_ENV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [LENGTH_BITS-1:0] attack_q, hold_len_q, decay_q, release_q;
  logic [SUS_W-1:0]       sustain_q;

  // Envelope state.
  logic [LEVEL_W-1:0]     level_q, level_d;
  logic [PHASE_W-1:0]     phase_q, phase_d;
  logic [LENGTH_BITS-1:0] hold_cnt_q, hold_cnt_d;
  logic [LEVEL_W-1:0]     rel_step_q, rel_step_d;
  logic                   num_nz_q, num_nz_d;
  logic                   out_valid_q, out_valid_d;

  // Item payload and results.
  logic [CMD_W-1:0]              cmd_q, cmd_d;
  logic signed [SAMPLE_BITS-1:0] audio_q, audio_d;
  logic signed [SAMPLE_BITS-1:0] audio_out_q, audio_out_d;
  logic [ENV_W-1:0]              env_out_q, env_out_d;
  logic [PHASE_W-1:0]            phase_out_q, phase_out_d;

  // Shared units.
  logic                          div_start, div_done;
  logic [LEVEL_W-1:0]            div_num, div_quot, div_step;
  logic [LENGTH_BITS-1:0]        div_den;
  logic                          mul_start, mul_done;
  logic signed [SAMPLE_BITS-1:0] mul_prod;

  logic                   in_acc;
  logic [LEVEL_W-1:0]     sus_q31;
  logic [LEVEL_W-1:0]     unity_minus_sus;
  logic [LENGTH_BITS-1:0] hold_inc;
  logic [LEVEL_W:0]       attack_sum;
  logic [ENV_W-1:0]       env_calc;

  assign in_acc          = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready     = (state_q == S_IDLE);
  assign cfg_i.ready     = 1'b1;
  assign sus_q31         = sustain_to_q31(sustain_q);
  assign unity_minus_sus = UNITY_Q31 - sus_q31;
  assign hold_inc        = (hold_cnt_q != '1) ? hold_cnt_q + LENGTH_BITS'(1) : hold_cnt_q;
  assign attack_sum      = {1'b0, level_q} + {1'b0, div_step};
  assign env_calc        = level_to_env(level_q);

  // A nonzero step that rounds to zero is raised to one.
  assign div_step = (div_quot == '0 && num_nz_q) ? LEVEL_W'(1) : div_quot;

  ahdsr_div #(
    .DEN_W (LENGTH_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  ahdsr_mul #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .sample_i (audio_q),
    .env_i    (env_calc),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  // Command sequencer and envelope update.
  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    phase_d     = phase_q;
    hold_cnt_d  = hold_cnt_q;
    rel_step_d  = rel_step_q;
    num_nz_d    = num_nz_q;
    cmd_d       = cmd_q;
    audio_d     = audio_q;
    audio_out_d = audio_out_q;
    env_out_d   = env_out_q;
    phase_out_d = phase_out_q;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    mul_start   = 1'b0;

    // The result register empties when its item is taken.
    out_valid_d = out_valid_q && !res_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d   = cmd_i.command;
          audio_d = cmd_i.audio_in;
          state_d = S_ENV;
          unique case (cmd_i.command)
            CMD_NOTE_ON: begin
              level_d    = '0;
              phase_d    = PH_ATTACK;
              hold_cnt_d = '0;
            end
            CMD_RESET: begin
              level_d    = '0;
              phase_d    = PH_IDLE;
              hold_cnt_d = '0;
              rel_step_d = '0;
            end
            CMD_NOTE_OFF: begin
              // The release slope is fixed by the level at note off.
              phase_d = PH_RELEASE;
              if (release_q == '0) begin
                rel_step_d = level_q;
              end else begin
                div_start = 1'b1;
                div_num   = level_q;
                div_den   = release_q;
                num_nz_d  = (level_q != '0);
                state_d   = S_DIV;
              end
            end
            CMD_TICK: begin
              unique case (phase_q)
                PH_ATTACK: begin
                  if (attack_q == '0) begin
                    level_d = UNITY_Q31;
                    phase_d = PH_HOLD;
                  end else begin
                    div_start = 1'b1;
                    div_num   = UNITY_Q31;
                    div_den   = attack_q;
                    num_nz_d  = 1'b1;
                    state_d   = S_DIV;
                  end
                end
                PH_HOLD: begin
                  hold_cnt_d = hold_inc;
                  if (hold_inc >= hold_len_q) begin
                    phase_d = PH_DECAY;
                  end
                end
                PH_DECAY: begin
                  if (decay_q == '0) begin
                    level_d = sus_q31;
                    phase_d = PH_SUSTAIN;
                  end else begin
                    div_start = 1'b1;
                    div_num   = unity_minus_sus;
                    div_den   = decay_q;
                    num_nz_d  = (sus_q31 != UNITY_Q31);
                    state_d   = S_DIV;
                  end
                end
                PH_RELEASE: begin
                  if (rel_step_q >= level_q) begin
                    level_d = '0;
                    phase_d = PH_IDLE;
                  end else begin
                    level_d = level_q - rel_step_q;
                  end
                end
                default: begin
                  // Idle and sustain hold their level.
                end
              endcase
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          priority if (cmd_q == CMD_NOTE_OFF) begin
            rel_step_d = div_step;
            state_d    = S_ENV;
          end else if (phase_q == PH_ATTACK) begin
            if (attack_sum >= {1'b0, UNITY_Q31}) begin
              level_d = UNITY_Q31;
              phase_d = PH_HOLD;
            end else begin
              level_d = attack_sum[LEVEL_W-1:0];
            end
            state_d = S_ENV;
          end else begin
            // Decay: saturating step down, then the sustain compare.
            level_d = (div_step >= level_q) ? '0 : level_q - div_step;
            state_d = S_DCMP;
          end
        end
      end
      S_DCMP: begin
        if (level_q <= sus_q31) begin
          level_d = sus_q31;
          phase_d = PH_SUSTAIN;
        end
        state_d = S_ENV;
      end
      S_ENV: begin
        if (cmd_q == CMD_TICK) begin
          mul_start = 1'b1;
          state_d   = S_MUL;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // The level stays put until the next command, so the envelope is read here.
        if (!out_valid_q || res_o.ready) begin
          audio_out_d = (cmd_q == CMD_TICK) ? mul_prod : '0;
          env_out_d   = env_calc;
          phase_out_d = phase_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and envelope state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      phase_q     <= PH_IDLE;
      hold_cnt_q  <= '0;
      rel_step_q  <= '0;
      num_nz_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      phase_q     <= phase_d;
      hold_cnt_q  <= hold_cnt_d;
      rel_step_q  <= rel_step_d;
      num_nz_q    <= num_nz_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item payload and result registers.
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    audio_q     <= audio_d;
    audio_out_q <= audio_out_d;
    env_out_q   <= env_out_d;
    phase_out_q <= phase_out_d;
  end

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q   <= LENGTH_BITS'(480);
      hold_len_q <= '0;
      decay_q    <= LENGTH_BITS'(4800);
      sustain_q  <= SUS_W'(52428);
      release_q  <= LENGTH_BITS'(4800);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_ATTACK:  attack_q   <= cfg_i.data[LENGTH_BITS-1:0];
        REG_HOLD:    hold_len_q <= cfg_i.data[LENGTH_BITS-1:0];
        REG_DECAY:   decay_q    <= cfg_i.data[LENGTH_BITS-1:0];
        REG_SUSTAIN: sustain_q  <= cfg_i.data[SUS_W-1:0];
        REG_RELEASE: release_q  <= cfg_i.data[LENGTH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.audio_out    = audio_out_q;
  assign res_o.envelope_out = env_out_q;
  assign res_o.phase_out    = phase_out_q;

  // An accepted command always starts the sequencer.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after accepting an item");

  // The level never rises above full scale.
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= UNITY_Q31)
    else $error("level above full scale");

  // Idle is only reached with the level at zero.
  a_idle_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> level_q == '0)
    else $error("idle phase with nonzero level");

  // Hold always sits at full scale.
  a_hold_at_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HOLD |-> level_q == UNITY_Q31)
    else $error("hold phase below full scale");

  // The divider finishes only while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider result arrived outside the divide state");

endmodule

/* hdl/ahdsr_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle over the level width.
// Depends on ahdsr_pkg for the level width.
module ahdsr_div import ahdsr_pkg::*; #(
  parameter int unsigned DEN_W = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [LEVEL_W-1:0] num_i,
  input  logic [DEN_W-1:0]   den_i,
  output logic               done_o,
  output logic [LEVEL_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(LEVEL_W + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LEVEL_W-1:0] nq_q, nq_d;
  logic [DEN_W-1:0]   rem_q, rem_d;
  logic [DEN_W-1:0]   den_q, den_d;
  logic [DEN_W:0]     rem_sh;
  logic [DEN_W:0]     rem_sub;
  logic               fits;

  // One trial subtraction: shift in the next numerator bit.
  assign rem_sh  = {rem_q, nq_q[LEVEL_W-1]};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    nq_d   = nq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(LEVEL_W);
      nq_d   = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      // Numerator bits leave at the top while quotient bits enter at the bottom.
      nq_d  = {nq_q[LEVEL_W-2:0], fits};
      rem_d = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

/* hdl/ahdsr_mul.sv */
// Bit-serial shift-and-add multiplier of a signed sample by the unsigned envelope.
// Depends on ahdsr_pkg for the envelope width.
module ahdsr_mul import ahdsr_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [ENV_W-1:0]              env_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] prod_o
);

  localparam int unsigned PROD_W = SAMPLE_BITS + ENV_W;
  localparam int unsigned CNT_W  = $clog2(ENV_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] mcand_q, mcand_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [ENV_W-1:0]  mplier_q, mplier_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    mplier_d = mplier_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = CNT_W'(ENV_W);
      mcand_d  = {{ENV_W{sample_i[SAMPLE_BITS-1]}}, sample_i};
      acc_d    = '0;
      mplier_d = env_i;
    end else if (busy_q) begin
      // Add the shifted sample for each set envelope bit, LSB first.
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[PROD_W-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[ENV_W-1:1]};
      cnt_d    = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
    mplier_q <= mplier_d;
  end

  // The product fits in PROD_W bits; dropping the low envelope bits floors it.
  assign done_o = done_q;
  assign prod_o = acc_q[PROD_W-1:ENV_W];

endmodule

/* tb/sv/ahdsr_envelope_generator_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the AHDSR envelope generator: directed envelopes, then
// random note sequences under several idling patterns. Needs ahdsr_pkg and the
// channel interfaces ahdsr_in_if, ahdsr_out_if and ahdsr_cfg_if.
module ahdsr_envelope_generator_test;
  import ahdsr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned BATCH_ITEMS   = 54;
  localparam logic [63:0] FULL_SCALE    = 64'h8000_0000;
  localparam logic [23:0] LENGTH_MAX    = 24'hFF_FFFF;

  // One result item as the block should report it.
  typedef struct packed {
    logic signed [15:0] audio;
    logic [ENV_W-1:0]   env;
    logic [PHASE_W-1:0] phase;
  } env_result_t;

  logic clk_i;
  logic rst_ni;

  ahdsr_in_if  #(.SAMPLE_BITS(16)) cmd_if ();
  ahdsr_out_if #(.SAMPLE_BITS(16)) res_if ();
  ahdsr_cfg_if                     cfg_if ();

  ahdsr_envelope_generator #(
    .LENGTH_BITS(24),
    .SAMPLE_BITS(16)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // Envelope state and register copies, starting from their reset values.
  logic [63:0]        lvl       = '0;
  logic [PHASE_W-1:0] ph        = PH_IDLE;
  logic [23:0]        hold_cnt  = '0;
  logic [63:0]        rel_step  = '0;
  logic [23:0]        atk_len   = 24'd480;
  logic [23:0]        hld_len   = 24'd0;
  logic [23:0]        dec_len   = 24'd4800;
  logic [15:0]        sus_lvl   = 16'd52428;
  logic [23:0]        rel_len   = 24'd4800;

  env_result_t pending_envelopes[$];
  int unsigned fail_count   = 0;
  int unsigned items_sent   = 0;
  int unsigned cycle_count  = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;

  // Free-running clock; the single reset at the start is driven by the test sequence.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL ahdsr_envelope_generator");
      $finish;
    end
  end

  // Linear step that never rounds to zero unless the distance is zero.
  function automatic logic [63:0] seg_step(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    q = num / den;
    if (q == 0 && num != 0) begin
      q = 64'd1;
    end
    return q;
  endfunction

  // Applies one command to the envelope state and returns the result item it causes.
  function automatic env_result_t predict_envelope(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [15:0] smp);
    env_result_t r;
    logic [63:0] sus;
    logic [63:0] step;
    logic [15:0] env;
    longint      prod;
    case (cmd)
      CMD_NOTE_ON: begin
        lvl      = '0;
        ph       = PH_ATTACK;
        hold_cnt = '0;
      end
      CMD_NOTE_OFF: begin
        ph = PH_RELEASE;
        rel_step = (rel_len == 0) ? lvl : seg_step(lvl, {40'd0, rel_len});
      end
      CMD_RESET: begin
        lvl      = '0;
        ph       = PH_IDLE;
        hold_cnt = '0;
        rel_step = '0;
      end
      default: begin
        case (ph)
          PH_ATTACK: begin
            if (atk_len == 0) begin
              lvl = FULL_SCALE;
            end else begin
              lvl = lvl + seg_step(FULL_SCALE, {40'd0, atk_len});
            end
            if (lvl >= FULL_SCALE) begin
              lvl = FULL_SCALE;
              ph  = PH_HOLD;
            end
          end
          PH_HOLD: begin
            if (hold_cnt != LENGTH_MAX) begin
              hold_cnt = hold_cnt + 1;
            end
            if (hold_cnt >= hld_len) begin
              ph = PH_DECAY;
            end
          end
          PH_DECAY: begin
            sus = ({48'd0, sus_lvl} << 31) / 64'd65535;
            if (dec_len == 0) begin
              lvl = sus;
            end else begin
              step = seg_step(FULL_SCALE - sus, {40'd0, dec_len});
              lvl  = (step >= lvl) ? 64'd0 : lvl - step;
            end
            if (lvl <= sus) begin
              lvl = sus;
              ph  = PH_SUSTAIN;
            end
          end
          PH_RELEASE: begin
            lvl = (rel_step >= lvl) ? 64'd0 : lvl - rel_step;
            if (lvl == 0) begin
              ph = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
    endcase
    env = 16'((lvl * 64'd65535) >> 31);
    if (cmd == CMD_TICK) begin
      prod    = longint'(smp) * longint'(env);
      r.audio = 16'(prod >>> 16);
    end else begin
      r.audio = '0;
    end
    r.env   = env;
    r.phase = ph;
    return r;
  endfunction

  // Sends one command item, idling first at random, and records what it should yield.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic signed [15:0] smp);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= cmd;
    cmd_if.audio_in <= smp;
    do @(posedge clk_i); while (!cmd_if.ready);
    pending_envelopes.push_back(predict_envelope(cmd, smp));
    items_sent++;
  endtask

  task automatic send_tick(input logic signed [15:0] smp);
    send_cmd(CMD_TICK, smp);
  endtask

  // Stops sending and waits until every result item has been taken.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (pending_envelopes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One register write; valid stays high so that back-to-back writes need no gap.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_ATTACK:  atk_len = data[23:0];
      REG_HOLD:    hld_len = data[23:0];
      REG_DECAY:   dec_len = data[23:0];
      REG_SUSTAIN: sus_lvl = data[15:0];
      REG_RELEASE: rel_len = data[23:0];
      default: begin
      end
    endcase
  endtask

  // Programs all registers once the block is idle. Unused upper data bits and an
  // index past the register list are exercised along the way; both must be ignored.
  task automatic configure(input logic [23:0] atk, input logic [23:0] hld,
                           input logic [23:0] dec, input logic [15:0] sus,
                           input logic [23:0] rel);
    drain_results();
    write_reg(CFG_IDX_W'(5 + $urandom_range(2)), $urandom);
    write_reg(REG_ATTACK,  {8'($urandom), atk});
    write_reg(REG_HOLD,    {8'($urandom), hld});
    write_reg(REG_DECAY,   {8'($urandom), dec});
    write_reg(REG_SUSTAIN, {16'($urandom), sus});
    write_reg(REG_RELEASE, {8'($urandom), rel});
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_audio();
    logic signed [15:0] a;
    case ($urandom_range(19))
      0:       a = 16'sh8000;
      1:       a = 16'sh7FFF;
      default: a = 16'($urandom);
    endcase
    return a;
  endfunction

  // Lengths are mostly short so that envelopes run through every phase.
  function automatic logic [23:0] rand_length();
    logic [23:0] n;
    case ($urandom_range(19))
      0, 1:    n = '0;
      2:       n = LENGTH_MAX;
      3:       n = 24'($urandom);
      default: n = 24'($urandom_range(1, 12));
    endcase
    return n;
  endfunction

  function automatic logic [15:0] rand_sustain();
    logic [15:0] s;
    case ($urandom_range(9))
      0:       s = '0;
      1:       s = 16'hFFFF;
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  // Result checker: each taken result is compared with the oldest expectation.
  initial begin
    env_result_t want;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        if (pending_envelopes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result item with none expected: audio %0d env %0d phase %0d",
                     res_if.audio_out, res_if.envelope_out, res_if.phase_out);
          end
        end else begin
          want = pending_envelopes.pop_front();
          if (res_if.audio_out !== want.audio || res_if.envelope_out !== want.env ||
              res_if.phase_out !== want.phase) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected audio %0d env %0d phase %0d, got %0d %0d %0d",
                       want.audio, want.env, want.phase, res_if.audio_out,
                       res_if.envelope_out, res_if.phase_out);
            end
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Short segments walked through every phase, with a note off while idle.
  task automatic test_full_envelope();
    configure(24'd2, 24'd1, 24'd2, 16'd32768, 24'd2);
    send_tick(16'sh7FFF);
    send_cmd(CMD_NOTE_OFF, 16'sh0000);
    send_tick(16'sh8000);
    send_cmd(CMD_NOTE_ON, 16'shFFFF);
    send_tick(16'sh7FFF);
    send_tick(16'sh8000);
    send_tick(-16'sd1);
    send_tick(16'sh7FFF);
    send_tick(16'sh8000);
    send_cmd(CMD_NOTE_OFF, 16'sh7FFF);
    send_tick(16'sh1234);
    send_tick(16'sh8000);
    send_cmd(CMD_RESET, 16'sh8000);
  endtask

  // Zero lengths end each segment at once; zero hold still spends one tick.
  task automatic test_zero_lengths();
    configure(24'd0, 24'd0, 24'd0, 16'hFFFF, 24'd0);
    send_cmd(CMD_NOTE_ON, 16'sh0000);
    send_tick(16'sh7FFF);
    send_tick(16'sh8000);
    send_tick(16'sh7FFF);
    send_cmd(CMD_NOTE_OFF, 16'sh0000);
    send_tick(16'sh8000);
  endtask

  // Steps that round to zero, and register changes while an envelope is running.
  task automatic test_live_changes();
    configure(24'd1, 24'd0, LENGTH_MAX, 16'd65534, LENGTH_MAX);
    send_cmd(CMD_NOTE_ON, 16'sh0000);
    send_tick(16'sh7FFF);
    send_tick(16'sh8000);
    send_tick(16'sh7FFF);
    // Raising sustain above the decaying level makes the next tick jump to it.
    configure(24'd1, 24'd0, LENGTH_MAX, 16'hFFFF, LENGTH_MAX);
    send_tick(16'sh8000);
    // Lowering sustain while sustaining leaves the level alone.
    configure(24'd1, 24'd0, LENGTH_MAX, 16'd0, LENGTH_MAX);
    send_tick(16'sh7FFF);
    send_cmd(CMD_NOTE_OFF, 16'sh0000);
    // The release step was captured at note off.
    configure(24'd1, 24'd0, LENGTH_MAX, 16'd0, 24'd0);
    send_tick(16'sh8000);
  endtask

  // Random note sequences under one idling pattern, with fresh settings per batch.
  task automatic test_random_envelopes(input int unsigned src_pct, input int unsigned snk_pct);
    int unsigned start;
    int unsigned n;
    drain_results();
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int b = 0; b < 5; b++) begin
      configure(rand_length(), rand_length(), rand_length(), rand_sustain(), rand_length());
      start = items_sent;
      while (items_sent - start < BATCH_ITEMS) begin
        if ($urandom_range(99) < 12) begin
          send_cmd(CMD_W'($urandom), rand_audio());
        end else begin
          send_cmd(CMD_NOTE_ON, rand_audio());
          n = $urandom_range(24);
          repeat (n) send_tick(rand_audio());
          if ($urandom_range(99) < 85) begin
            send_cmd(CMD_NOTE_OFF, rand_audio());
          end
          n = $urandom_range(14);
          repeat (n) send_tick(rand_audio());
          if ($urandom_range(99) < 10) begin
            send_cmd(CMD_RESET, rand_audio());
          end
        end
      end
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni          <= 1'b0;
    cmd_if.valid    <= 1'b0;
    cmd_if.command  <= CMD_TICK;
    cmd_if.audio_in <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_ATTACK;
    cfg_if.data     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_envelope();
    test_zero_lengths();
    test_live_changes();
    test_random_envelopes(0, 0);
    test_random_envelopes(51, 0);
    test_random_envelopes(0, 51);
    test_random_envelopes(13, 13);

    drain_results();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending_envelopes.size() == 0) begin
      $display("PASS ahdsr_envelope_generator");
    end else begin
      $display("FAIL ahdsr_envelope_generator");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ahdsr_pkg.sv
hdl/ahdsr_in_if.sv
hdl/ahdsr_out_if.sv
hdl/ahdsr_cfg_if.sv
hdl/ahdsr_div.sv
hdl/ahdsr_mul.sv
hdl/ahdsr_envelope_generator.sv
tb/sv/ahdsr_envelope_generator_test.sv
